>>> rtl/core/avdd_pkg.sv
`timescale 1ns / 1ps

package avdd_pkg;

  // Width of the configuration registers (volts, 1..99).
  localparam int unsigned VOLT_W = 7;

  // Width of the second operand of the shared multiplier.
  localparam int unsigned MUL_B_W = 13;

  // Reading in hundredths or thousandths, saturated to four digits.
  localparam int unsigned VAL_W = 14;
  localparam int unsigned Q_W   = 10;
  localparam int unsigned DIG_W = 4;
  localparam int unsigned NUM_DIGITS = 4;

  localparam logic [VAL_W-1:0]   READING_MAX = VAL_W'(9999);
  localparam logic [MUL_B_W-1:0] SCALE_HUNDREDTHS  = MUL_B_W'(100);
  localparam logic [MUL_B_W-1:0] SCALE_THOUSANDTHS = MUL_B_W'(1000);

  // floor(v / 10) == (v * 6554) >> 16 for every v up to 9999.
  localparam logic [MUL_B_W-1:0] RECIP_TEN = MUL_B_W'(6554);
  localparam int unsigned DIV_SHIFT = 16;

  localparam logic [VOLT_W-1:0] FULL_SCALE_RESET = VOLT_W'(25);
  localparam logic [VOLT_W-1:0] THRESHOLD_RESET  = VOLT_W'(10);

  typedef enum logic [0:0] {
    CFG_FULL_SCALE = 1'b0,
    CFG_THRESHOLD  = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic busy;
    logic low_range;
  } seq_status_t;

  typedef logic [DIG_W-1:0] digit_t;

  // Segments a..g in bits 0..6; codes above nine leave every segment dark.
  function automatic logic [6:0] seg_decode(input digit_t d);
    logic [6:0] s;
    begin
      case (d)
        4'd0:    s = 7'h3F;
        4'd1:    s = 7'h06;
        4'd2:    s = 7'h5B;
        4'd3:    s = 7'h4F;
        4'd4:    s = 7'h66;
        4'd5:    s = 7'h6D;
        4'd6:    s = 7'h7D;
        4'd7:    s = 7'h07;
        4'd8:    s = 7'h7F;
        4'd9:    s = 7'h6F;
        default: s = 7'h00;
      endcase
      return s;
    end
  endfunction

endpackage

>>> rtl/core/avdd_mul.sv
`timescale 1ns / 1ps

module avdd_mul
  import avdd_pkg::*;
#(
  parameter int unsigned A_W = 17
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [A_W-1:0]         a_i,
  input  logic [MUL_B_W-1:0]     b_i,
  output logic [A_W+MUL_B_W-1:0] p_o
);

  logic [A_W+MUL_B_W-1:0] p_q;

  // The product is registered; it is valid the cycle after the operands.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (A_W+MUL_B_W)'(a_i) * (A_W+MUL_B_W)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/avdd_seq.sv
`timescale 1ns / 1ps

module avdd_seq
  import avdd_pkg::*;
#(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [ADC_BITS-1:0]                   code_i,
  input  logic [VOLT_W-1:0]                     full_scale_i,
  input  logic [VOLT_W-1:0]                     threshold_i,
  output logic                                  mul_en_o,
  output logic [VOLT_W+ADC_BITS-1:0]            mul_a_o,
  output logic [MUL_B_W-1:0]                    mul_b_o,
  input  logic [VOLT_W+ADC_BITS+MUL_B_W-1:0]    mul_p_i,
  output seq_status_t                           status_o,
  output digit_t                                digits_o [NUM_DIGITS]
);

  localparam int unsigned PROD_W = VOLT_W + ADC_BITS;
  localparam int unsigned SCL_W  = PROD_W + MUL_B_W - ADC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_RANGE,
    ST_SCALE,
    ST_DIV
  } state_e;

  state_e                state_q, state_d;
  logic [ADC_BITS-1:0]   code_q, code_d;
  logic [VAL_W-1:0]      val_q, val_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  low_q, low_d;
  digit_t                dig_q [NUM_DIGITS];
  digit_t                dig_d [NUM_DIGITS];

  logic [PROD_W-1:0]     prod;
  logic [SCL_W-1:0]      scaled;
  logic [VAL_W-1:0]      sat_val;
  logic [Q_W-1:0]        quot;
  logic [VAL_W-1:0]      rem;
  logic                  hi_range;

  assign prod     = mul_p_i[PROD_W-1:0];
  assign hi_range = prod >= {threshold_i, {ADC_BITS{1'b0}}};
  assign scaled   = mul_p_i[ADC_BITS +: SCL_W];
  assign sat_val  = (scaled > SCL_W'(READING_MAX)) ? READING_MAX : scaled[VAL_W-1:0];
  assign quot     = mul_p_i[DIV_SHIFT +: Q_W];
  // Remainder of the division by ten: v - 8q - 2q.
  assign rem      = val_q - VAL_W'({quot, 3'b000}) - VAL_W'({quot, 1'b0});

  always_comb begin
    state_d  = state_q;
    code_d   = code_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    low_d    = low_q;
    dig_d    = dig_q;
    mul_en_o = 1'b0;
    mul_a_o  = '0;
    mul_b_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          code_d  = code_i;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        mul_en_o = 1'b1;
        mul_a_o  = PROD_W'(code_q);
        mul_b_o  = MUL_B_W'(full_scale_i);
        state_d  = ST_RANGE;
      end
      ST_RANGE: begin
        low_d    = ~hi_range;
        mul_en_o = 1'b1;
        mul_a_o  = prod;
        mul_b_o  = hi_range ? SCALE_HUNDREDTHS : SCALE_THOUSANDTHS;
        state_d  = ST_SCALE;
      end
      ST_SCALE: begin
        val_d    = sat_val;
        cnt_d    = '0;
        mul_en_o = 1'b1;
        mul_a_o  = PROD_W'(sat_val);
        mul_b_o  = RECIP_TEN;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        dig_d[2'd3 - cnt_q] = rem[DIG_W-1:0];
        val_d = VAL_W'(quot);
        if (cnt_q == 2'd2) begin
          dig_d[0] = quot[DIG_W-1:0];
          state_d  = ST_IDLE;
        end else begin
          mul_en_o = 1'b1;
          mul_a_o  = PROD_W'(quot);
          mul_b_o  = RECIP_TEN;
          cnt_d    = cnt_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      low_q   <= 1'b0;
      cnt_q   <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      cnt_q   <= cnt_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    val_q  <= val_d;
  end

  assign status_o.busy      = (state_q != ST_IDLE);
  assign status_o.low_range = low_q;
  assign digits_o           = dig_q;

endmodule

>>> rtl/core/autorange_voltmeter_display_driver.sv
`timescale 1ns / 1ps

// Channel    | Direction | Handshake                      | Payload
// -----------+-----------+--------------------------------+------------------------------------
// s_axis     | in        | s_axis_tvalid / s_axis_tready  | tuser: kind, tdata: converter code
// m_axis     | out       | m_axis_tvalid / m_axis_tready  | tdata: segments, dot, digit index
// cfg        | in        | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// A scan tick leaves its result in the output register.
// A converter sample is worked in steps: capture, three passes through the shared
// multiplier (scale to volts, scale to hundredths or thousandths, first divide by ten)
// and then two further divide-by-ten passes, one per cycle. Samples give no output
// transaction.
// Reset clears the digit store to zeros, the range to hundredths and the scan
// position to three, so the first tick shows digit zero.
// The input is held off while a sample is being worked on, or while an earlier
// result has not yet been taken and is not being taken in the same cycle.
module autorange_voltmeter_display_driver
  import avdd_pkg::*;
#(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input transactions.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Bit 0: func (0 sample, 1 scan tick).
  input  logic                            s_axis_tuser,
  // Bits ADC_BITS-1..0: adc_code; remaining bits are padding.
  input  logic [((ADC_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // Output transactions.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Bits 6..0: segments, bit 7: dot, bits 9..8: digit_index, 15..10: zero.
  output logic [15:0]                     m_axis_tdata,
  // Configuration writes.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [0:0]                      cfg_index_i,
  input  logic [VOLT_W-1:0]               cfg_data_i
);

  localparam int unsigned PROD_W = VOLT_W + ADC_BITS;

  // Configuration registers, written whenever the port presents a write.
  logic [VOLT_W-1:0] full_scale_q;
  logic [VOLT_W-1:0] threshold_q;

  // Display scan and the registered output transaction.
  logic [1:0]        scan_q, scan_d;
  logic              out_valid_q;
  logic [6:0]        out_seg_q;
  logic              out_dot_q;
  logic [1:0]        out_idx_q;

  logic              in_fire;
  logic              tick_fire;
  logic              sample_fire;
  logic              dot_d;

  logic                       mul_en;
  logic [PROD_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [PROD_W+MUL_B_W-1:0]  mul_p;
  seq_status_t                seq_status;
  digit_t                     digits [NUM_DIGITS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RESET;
      threshold_q  <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A new transaction is taken only when the sequencer is idle and the output
  // register is free or being emptied in this cycle.
  assign s_axis_tready = ~seq_status.busy & (~out_valid_q | m_axis_tready);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign tick_fire     = in_fire & (item_kind_e'(s_axis_tuser) == KIND_TICK);
  assign sample_fire   = in_fire & (item_kind_e'(s_axis_tuser) == KIND_SAMPLE);

  // The decimal point sits after the first digit in the thousandths range and
  // after the second digit in the hundredths range.
  assign scan_d = scan_q + 2'd1;
  assign dot_d  = seq_status.low_range ? (scan_d == 2'd0) : (scan_d == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= 2'd3;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_fire) begin
        scan_q      <= scan_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_seg_q <= seg_decode(digits[scan_d]);
      out_dot_q <= dot_d;
      out_idx_q <= scan_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_idx_q, out_dot_q, out_seg_q};

  avdd_seq #(
    .ADC_BITS (ADC_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (sample_fire),
    .code_i       (s_axis_tdata[ADC_BITS-1:0]),
    .full_scale_i (full_scale_q),
    .threshold_i  (threshold_q),
    .mul_en_o     (mul_en),
    .mul_a_o      (mul_a),
    .mul_b_o      (mul_b),
    .mul_p_i      (mul_p),
    .status_o     (seq_status),
    .digits_o     (digits)
  );

  avdd_mul #(
    .A_W (PROD_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

endmodule

>>> rtl/core/avdd_checker.sv
`timescale 1ns / 1ps

module avdd_checker #(
  parameter int unsigned ADC_BITS = 10
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [15:0]                   m_axis_tdata
);

  // A waiting result is neither dropped nor altered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // A sample keeps the input closed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input accepted while a sample is being converted");

  // Every tick gives an output transaction in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> m_axis_tvalid)
    else $error("tick produced no output transaction");

  // Stored digits never exceed nine, so some segment is always lit; the padding stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] != 7'h00) && (m_axis_tdata[15:10] == 6'h00))
    else $error("blank digit or non-zero padding on output");

endmodule

bind autorange_voltmeter_display_driver avdd_checker #(
  .ADC_BITS (ADC_BITS)
) u_avdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
